// ===== design/pll_angle_speed_tracker_macros.svh =====
// Assertion helpers used by the tracker control module.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef PLL_ANGLE_SPEED_TRACKER_MACROS_SVH
`define PLL_ANGLE_SPEED_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLLTRK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLLTRK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/plltrk_pkg.sv =====
package plltrk_pkg;

    // angle resolution of the measured and reported angle
    localparam int ANGLE_BITS = 16;

    localparam int ACC_W   = 32;              // angle accumulator, Q0.32 turns
    localparam int SPEED_W = 48;              // speed accumulator, Q16.32 turns/s
    localparam int REG_W   = 32;              // configuration register width
    localparam int OUT_W   = 32;              // speed outputs, Q24.8
    localparam int PROD_W  = 2 * REG_W;       // one multiplier product
    localparam int RAD_W   = 27;              // rad/s magnitude never exceeds this
    localparam int RPM_W   = 29;              // rpm magnitude never exceeds this

    localparam int IN_TDATA_W  = ((ANGLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * OUT_W + ANGLE_BITS + 7) / 8) * 8;

    // 2*pi in Q4.28
    localparam logic [REG_W-1:0] TWO_PI_Q28 = 32'd1686629713;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEGRAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;

    localparam logic [REG_W-1:0] GAIN_PROP_RST     = 32'd0;
    localparam logic [REG_W-1:0] GAIN_INTEGRAL_RST = 32'd0;
    localparam logic [REG_W-1:0] SAMPLE_PERIOD_RST = 32'd1;

    // multiplier operand selection
    localparam int MUL_SEL_W = 2;
    localparam logic [MUL_SEL_W-1:0] MUL_GAIN  = 2'd0; // ki*|err|, kp*|err|
    localparam logic [MUL_SEL_W-1:0] MUL_IPATH = 2'd1; // (ki*|err|)*dt, split
    localparam logic [MUL_SEL_W-1:0] MUL_RATE  = 2'd2; // |speed|*2pi, split
    localparam logic [MUL_SEL_W-1:0] MUL_ADV   = 2'd3; // |speed+prop|*dt, split

    typedef struct packed {
        logic                 load_in;
        logic                 err;
        logic                 mul_en;
        logic [MUL_SEL_W-1:0] mul_sel;
        logic                 pmag;
        logic                 isum;
        logic                 speed;
        logic                 total;
        logic                 tabs;
        logic                 rad;
        logic                 dsum;
        logic                 commit;
    } t_dp_cmd;

endpackage

// ===== design/plltrk_ctrl.sv =====
`include "pll_angle_speed_tracker_macros.svh"

module plltrk_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output plltrk_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ERR   = 4'd1;
    localparam logic [3:0] ST_GAIN  = 4'd2;
    localparam logic [3:0] ST_IPATH = 4'd3;
    localparam logic [3:0] ST_ISUM  = 4'd4;
    localparam logic [3:0] ST_SPEED = 4'd5;
    localparam logic [3:0] ST_TOTAL = 4'd6;
    localparam logic [3:0] ST_RATE  = 4'd7;
    localparam logic [3:0] ST_ADV   = 4'd8;
    localparam logic [3:0] ST_DSUM  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign o_s_ready   = (r_state == ST_IDLE);
    assign o_m_valid   = r_out_valid;
    assign w_slot_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_ERR;
                end
            end
            ST_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = plltrk_pkg::MUL_GAIN;
                n_state       = ST_IPATH;
            end
            ST_IPATH: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = plltrk_pkg::MUL_IPATH;
                o_cmd.pmag    = 1'b1;
                n_state       = ST_ISUM;
            end
            ST_ISUM: begin
                o_cmd.isum = 1'b1;
                n_state    = ST_SPEED;
            end
            ST_SPEED: begin
                o_cmd.speed = 1'b1;
                n_state     = ST_TOTAL;
            end
            ST_TOTAL: begin
                o_cmd.total = 1'b1;
                n_state     = ST_RATE;
            end
            ST_RATE: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = plltrk_pkg::MUL_RATE;
                o_cmd.tabs    = 1'b1;
                n_state       = ST_ADV;
            end
            ST_ADV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = plltrk_pkg::MUL_ADV;
                o_cmd.rad     = 1'b1;
                n_state       = ST_DSUM;
            end
            ST_DSUM: begin
                o_cmd.dsum = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // hold here until the output register can take the result
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `PLLTRK_ASSERT_NEXT(a_accept_starts, i_s_valid && o_s_ready, r_state == ST_ERR,
        "accepted request did not start an update")
    `PLLTRK_ASSERT_NOW(a_commit_slot_free, o_cmd.commit, !r_out_valid || i_m_ready,
        "result committed over an untaken result")
    `PLLTRK_ASSERT_NEXT(a_commit_shows, o_cmd.commit, r_out_valid,
        "committed result not presented")
    `PLLTRK_ASSERT_NOW(a_valid_from_done, $rose(r_out_valid), $past(r_state == ST_DONE),
        "output valid rose outside the final step")

endmodule

// ===== design/plltrk_datapath.sv =====
module plltrk_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [plltrk_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [plltrk_pkg::REG_W-1:0]           i_cfg_data,
    input  logic [plltrk_pkg::ANGLE_BITS-1:0]      i_theta,
    input  plltrk_pkg::t_dp_cmd                    i_cmd,
    output logic [plltrk_pkg::OUT_W-1:0]           o_speed_rad,
    output logic [plltrk_pkg::OUT_W-1:0]           o_speed_rpm,
    output logic [plltrk_pkg::ANGLE_BITS-1:0]      o_angle
);

    localparam int AW = plltrk_pkg::ACC_W;
    localparam int SW = plltrk_pkg::SPEED_W;
    localparam int RW = plltrk_pkg::REG_W;
    localparam int PW = plltrk_pkg::PROD_W;
    localparam int AB = plltrk_pkg::ANGLE_BITS;
    localparam int OW = plltrk_pkg::OUT_W;
    localparam int MW = SW - 1;               // magnitude of a path term, < 2^47

    // configuration
    logic [RW-1:0] r_gain_prop;
    logic [RW-1:0] r_gain_int;
    logic [RW-1:0] r_period;

    // tracker state
    logic [AW-1:0] r_angle;
    logic [SW-1:0] r_speed;

    // working registers
    logic [AB-1:0]                  r_theta;
    logic [AW-1:0]                  r_emag;
    logic                           r_eneg;
    logic [PW-1:0]                  r_pa;
    logic [PW-1:0]                  r_pb;
    logic [MW-1:0]                  r_pmag;
    logic [MW-1:0]                  r_imag;
    logic [SW:0]                    r_total;
    logic [SW-1:0]                  r_smag;
    logic                           r_sneg;
    logic [SW-1:0]                  r_tmag;
    logic                           r_tneg;
    logic [plltrk_pkg::RPM_W-1:0]   r_rpm;
    logic [plltrk_pkg::RAD_W-1:0]   r_rad;
    logic [AW-1:0]                  r_dmag;
    logic [OW-1:0]                  r_out_rad;
    logic [OW-1:0]                  r_out_rpm;
    logic [AB-1:0]                  r_out_angle;

    logic [AW-1:0]   w_meas;
    logic [AW-1:0]   w_diff;
    logic [AW-1:0]   w_emag;
    logic [RW-1:0]   w_a1;
    logic [RW-1:0]   w_a2;
    logic [RW-1:0]   w_b1;
    logic [RW-1:0]   w_b2;
    logic [PW-1:0]   w_prod_a;
    logic [PW-1:0]   w_prod_b;
    logic [PW-1:0]   w_hsum;
    logic [SW:0]     w_imag_s;
    logic [SW:0]     w_pmag_s;
    logic [SW:0]     w_spd_sum;
    logic [SW-1:0]   w_spd_sat;
    logic [SW-1:0]   w_smag;
    logic [SW:0]     w_tabs;
    logic [SW+5:0]   w_rpm_full;
    logic [AW-1:0]   w_angle_next;
    logic [OW-1:0]   w_rad_ext;
    logic [OW-1:0]   w_rpm_ext;

    // wrapped error, magnitude at most half a turn
    assign w_meas = {r_theta, {(AW - AB){1'b0}}};
    assign w_diff = w_meas - r_angle;
    assign w_emag = w_diff[AW-1] ? (AW'(0) - w_diff) : w_diff;

    // two 32x32 multipliers, operands picked per step
    always_comb begin
        case (i_cmd.mul_sel)
            plltrk_pkg::MUL_GAIN: begin
                w_a1 = r_gain_int;
                w_a2 = r_emag;
                w_b1 = r_gain_prop;
                w_b2 = r_emag;
            end
            plltrk_pkg::MUL_IPATH: begin
                w_a1 = r_pa[PW-1:RW];
                w_a2 = r_period;
                w_b1 = r_pa[RW-1:0];
                w_b2 = r_period;
            end
            plltrk_pkg::MUL_RATE: begin
                w_a1 = RW'(r_smag[SW-1:RW]);
                w_a2 = plltrk_pkg::TWO_PI_Q28;
                w_b1 = r_smag[RW-1:0];
                w_b2 = plltrk_pkg::TWO_PI_Q28;
            end
            plltrk_pkg::MUL_ADV: begin
                w_a1 = RW'(r_tmag[SW-1:RW]);
                w_a2 = r_period;
                w_b1 = r_tmag[RW-1:0];
                w_b2 = r_period;
            end
            default: begin
                w_a1 = '0;
                w_a2 = '0;
                w_b1 = '0;
                w_b2 = '0;
            end
        endcase
    end

    assign w_prod_a = {{RW{1'b0}}, w_a1} * {{RW{1'b0}}, w_a2};
    assign w_prod_b = {{RW{1'b0}}, w_b1} * {{RW{1'b0}}, w_b2};

    // high partial plus carry-in of the low partial: exact (x*y) >> 32
    assign w_hsum = r_pa + {{RW{1'b0}}, r_pb[PW-1:RW]};

    // speed integration with saturation to the 48-bit range
    assign w_imag_s  = {2'b00, r_imag};
    assign w_spd_sum = {r_speed[SW-1], r_speed}
                     + (r_eneg ? ((SW + 1)'(0) - w_imag_s) : w_imag_s);

    always_comb begin
        if (!w_spd_sum[SW] && w_spd_sum[SW-1]) begin
            w_spd_sat = {1'b0, {(SW - 1){1'b1}}};
        end else if (w_spd_sum[SW] && !w_spd_sum[SW-1]) begin
            w_spd_sat = {1'b1, {(SW - 1){1'b0}}};
        end else begin
            w_spd_sat = w_spd_sum[SW-1:0];
        end
    end

    assign w_pmag_s = {2'b00, r_pmag};
    assign w_smag   = r_speed[SW-1] ? (SW'(0) - r_speed) : r_speed;
    assign w_tabs   = r_total[SW] ? ((SW + 1)'(0) - r_total) : r_total;

    // |speed| * 60 as shift and subtract
    assign w_rpm_full = {r_smag, 6'd0} - {4'd0, r_smag, 2'd0};

    assign w_angle_next = r_tneg ? (r_angle - r_dmag) : (r_angle + r_dmag);

    assign w_rad_ext = OW'(r_rad);
    assign w_rpm_ext = OW'(r_rpm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop <= plltrk_pkg::GAIN_PROP_RST;
            r_gain_int  <= plltrk_pkg::GAIN_INTEGRAL_RST;
            r_period    <= plltrk_pkg::SAMPLE_PERIOD_RST;
            r_angle     <= '0;
            r_speed     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    plltrk_pkg::CFG_GAIN_PROP:     r_gain_prop <= i_cfg_data;
                    plltrk_pkg::CFG_GAIN_INTEGRAL: r_gain_int  <= i_cfg_data;
                    plltrk_pkg::CFG_SAMPLE_PERIOD: r_period    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.speed) begin
                r_speed <= w_spd_sat;
            end
            if (i_cmd.commit) begin
                r_angle <= w_angle_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_theta <= i_theta;
        end
        if (i_cmd.err) begin
            r_emag <= w_emag;
            r_eneg <= w_diff[AW-1];
        end
        if (i_cmd.mul_en) begin
            r_pa <= w_prod_a;
            r_pb <= w_prod_b;
        end
        if (i_cmd.pmag) begin
            r_pmag <= r_pb[MW+15:16];
        end
        if (i_cmd.isum) begin
            r_imag <= w_hsum[MW+15:16];
        end
        if (i_cmd.total) begin
            r_total <= {r_speed[SW-1], r_speed}
                     + (r_eneg ? ((SW + 1)'(0) - w_pmag_s) : w_pmag_s);
            r_smag  <= w_smag;
            r_sneg  <= r_speed[SW-1];
        end
        if (i_cmd.tabs) begin
            r_tmag <= w_tabs[SW-1:0];
            r_tneg <= r_total[SW];
            r_rpm  <= w_rpm_full[plltrk_pkg::RPM_W+23:24];
        end
        if (i_cmd.rad) begin
            r_rad <= w_hsum[plltrk_pkg::RAD_W+19:20];
        end
        if (i_cmd.dsum) begin
            r_dmag <= r_pa[AW-1:0] + r_pb[PW-1:RW];
        end
        if (i_cmd.commit) begin
            // magnitudes stay well inside 32 bits, so no clamp is needed
            r_out_rad   <= r_sneg ? (OW'(0) - w_rad_ext) : w_rad_ext;
            r_out_rpm   <= r_sneg ? (OW'(0) - w_rpm_ext) : w_rpm_ext;
            r_out_angle <= w_angle_next[AW-1:AW-AB];
        end
    end

    assign o_speed_rad = r_out_rad;
    assign o_speed_rpm = r_out_rpm;
    assign o_angle     = r_out_angle;

endmodule

// ===== design/pll_angle_speed_tracker.sv =====
// Second-order PLL that tracks rotor angle and speed from measured angles.
// Input stream (s_axis): one request carries one measured angle, a 16-bit
// fraction of a turn. Output stream (m_axis): one result per request with
// speed in rad/s and RPM (signed Q24.8) and the updated angle estimate.
// Configuration: write kp (index 0), ki (index 1) and dt (index 2) through
// i_cfg_we / i_cfg_index / i_cfg_data while no request is in flight.
// Flow: the result is registered and shown on m_axis_tvalid once the last
// step commits, and a new request is accepted only after that; a controller
// steps the datapath through its dependent chain of two 32x32 multipliers,
// used four times per update, and the adds between them.
// Reset (i_rst_n low, synchronous): zero angle and speed, zero gains,
// dt = 1 LSB, drop any result that was waiting.
// Stall: a finished result waits in the output register; the next request
// is still accepted and worked on, and that update holds in its last step
// until the waiting result is taken.
module pll_angle_speed_tracker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // [15:0] theta_measured
    input  logic [plltrk_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [31:0] speed_rad_per_s, [63:32] speed_rpm, [79:64] angle_estimate
    output logic [plltrk_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    i_cfg_we,
    input  logic [plltrk_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [plltrk_pkg::REG_W-1:0]            i_cfg_data
);

    plltrk_pkg::t_dp_cmd                  w_cmd;
    logic [plltrk_pkg::OUT_W-1:0]         w_speed_rad;
    logic [plltrk_pkg::OUT_W-1:0]         w_speed_rpm;
    logic [plltrk_pkg::ANGLE_BITS-1:0]    w_angle;

    // sequence the update steps and own the output handshake
    plltrk_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd)
    );

    // error, multipliers, speed and angle state, output register
    plltrk_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_theta     (s_axis_tdata[plltrk_pkg::ANGLE_BITS-1:0]),
        .i_cmd       (w_cmd),
        .o_speed_rad (w_speed_rad),
        .o_speed_rpm (w_speed_rpm),
        .o_angle     (w_angle)
    );

    // pack fields from the lowest bit up, zero fill to whole bytes
    assign m_axis_tdata = plltrk_pkg::OUT_TDATA_W'({w_angle, w_speed_rpm, w_speed_rad});

endmodule
